[rtl/cas_pkg.sv]
// Shared types and constants of the cave smoothing automaton.
package cas_pkg;

	localparam int TOTAL_W = 17;
	localparam int COORD_W = 8;
	localparam int CFG_W = 4;

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_RUN   = 2'd2;

	localparam logic CFG_THRESHOLD = 1'b0;
	localparam logic CFG_PASSES    = 1'b1;

	localparam logic [CFG_W-1:0] THRESHOLD_RST = 4'd5;
	localparam logic [CFG_W-1:0] PASSES_RST    = 4'd2;

	typedef struct packed {
		logic               wall_out;
		logic [TOTAL_W-1:0] wall_total;
		logic               status;
	} rsp_t;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [1:0]         drow;
		logic [1:0]         dcol;
	} addr_req_t;

	typedef struct packed {
		logic we_a;
		logic we_b;
		logic wdata;
		logic sel_b;
	} mem_ctl_t;

endpackage

[rtl/cas_if.sv]
// Request and result channel interfaces of the cave smoothing automaton.
interface cas_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] row;
	logic [7:0] col;
	logic       wall_in;

	modport source (output valid, output req_type, output row, output col, output wall_in,
		input ready);
	modport sink (input valid, input req_type, input row, input col, input wall_in,
		output ready);
endinterface

interface cas_rsp_if;
	logic        valid;
	logic        ready;
	logic        wall_out;
	logic [16:0] wall_total;
	logic        status;

	modport source (output valid, output wall_out, output wall_total, output status,
		input ready);
	modport sink (input valid, input wall_out, input wall_total, input status,
		output ready);
endinterface

[rtl/cas_ram.sv]
// Generic single-port RAM with registered read data.
module cas_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

[rtl/cas_addr.sv]
// Shared address unit: toroidal neighbor wrap and linear cell address.
module cas_addr import cas_pkg::*; #(
	parameter int ROWS = 32,
	parameter int COLS = 64,
	parameter int AW   = 11
) (
	input  addr_req_t       areq,
	output logic [AW-1:0]   addr
);

	logic [COORD_W-1:0] rr;
	logic [COORD_W-1:0] cc;
	logic [TOTAL_W-1:0] lin;

	always_comb begin
		case (areq.drow)
			2'd0:    rr = (areq.row == '0) ? COORD_W'(ROWS - 1) : areq.row - 8'd1;
			2'd2:    rr = (areq.row == COORD_W'(ROWS - 1)) ? '0 : areq.row + 8'd1;
			default: rr = areq.row;
		endcase
		case (areq.dcol)
			2'd0:    cc = (areq.col == '0) ? COORD_W'(COLS - 1) : areq.col - 8'd1;
			2'd2:    cc = (areq.col == COORD_W'(COLS - 1)) ? '0 : areq.col + 8'd1;
			default: cc = areq.col;
		endcase
		lin  = TOTAL_W'(rr) * TOTAL_W'(COLS) + TOTAL_W'(cc);
		addr = lin[AW-1:0];
	end

endmodule

[rtl/cas_ctrl.sv]
// Sequencer for requests, smoothing passes and the final wall count.
module cas_ctrl import cas_pkg::*; #(
	parameter int ROWS = 32,
	parameter int COLS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [COORD_W-1:0] row,
	input  logic [COORD_W-1:0] col,
	input  logic               wall_in,
	input  logic [CFG_W-1:0]   threshold,
	input  logic [CFG_W-1:0]   passes,
	input  logic               rdata,
	input  logic               out_free,
	output addr_req_t          areq,
	output mem_ctl_t           mctl,
	output logic               done,
	output rsp_t               res
);

	localparam int RW = $clog2(ROWS);
	localparam int CW = $clog2(COLS);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_RDWAIT = 3'd1;
	localparam logic [2:0] S_PRD    = 3'd2;
	localparam logic [2:0] S_PWR    = 3'd3;
	localparam logic [2:0] S_CRD    = 3'd4;
	localparam logic [2:0] S_CLAST  = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0]         state_q;
	logic [RW-1:0]      r_q;
	logic [CW-1:0]      c_q;
	logic [1:0]         dr_q;
	logic [1:0]         dc_q;
	logic [3:0]         cnt_q;
	logic               vld_q;
	logic [CFG_W-1:0]   pass_q;
	logic               cur_q;
	logic [TOTAL_W-1:0] total_q;
	rsp_t               res_q;

	logic               in_range;
	logic               last_cell;
	logic               last_pass;
	logic [3:0]         sum;
	logic               cur_we;
	logic               nxt_we;

	assign in_range  = (9'(row) < 9'(ROWS)) && (9'(col) < 9'(COLS));
	assign last_cell = (r_q == RW'(ROWS - 1)) && (c_q == CW'(COLS - 1));
	assign last_pass = (5'(pass_q) + 5'd1) == 5'(passes);
	assign sum       = cnt_q + 4'(rdata);
	assign in_ready  = (state_q == S_IDLE);
	assign done      = (state_q == S_DONE);
	assign res       = res_q;

	always_comb begin
		areq   = '{row: 8'(r_q), col: 8'(c_q), drow: 2'd1, dcol: 2'd1};
		cur_we = 1'b0;
		nxt_we = 1'b0;
		mctl   = '0;
		case (state_q)
			S_IDLE: begin
				areq.row = row;
				areq.col = col;
				cur_we   = in_valid && (req_type == REQ_WRITE) && in_range;
			end
			S_PRD: begin
				areq.drow = dr_q;
				areq.dcol = dc_q;
			end
			S_PWR: begin
				nxt_we = 1'b1;
			end
			default: begin
			end
		endcase
		mctl.sel_b = cur_q;
		mctl.wdata = (state_q == S_PWR) ? (sum >= threshold) : wall_in;
		mctl.we_a  = cur_q ? nxt_we : cur_we;
		mctl.we_b  = cur_q ? cur_we : nxt_we;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					res_q <= '{wall_out: 1'b0, wall_total: '0,
						status: ((req_type == REQ_WRITE) || (req_type == REQ_READ)) && !in_range};
				end
			end
			S_RDWAIT: begin
				res_q.wall_out <= rdata;
			end
			S_CLAST: begin
				res_q.wall_total <= total_q + TOTAL_W'(rdata);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			r_q     <= '0;
			c_q     <= '0;
			dr_q    <= '0;
			dc_q    <= '0;
			cnt_q   <= '0;
			vld_q   <= 1'b0;
			pass_q  <= '0;
			cur_q   <= 1'b0;
			total_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					r_q     <= '0;
					c_q     <= '0;
					dr_q    <= '0;
					dc_q    <= '0;
					cnt_q   <= '0;
					vld_q   <= 1'b0;
					pass_q  <= '0;
					total_q <= '0;
					if (in_valid) begin
						case (req_type)
							REQ_READ:  state_q <= in_range ? S_RDWAIT : S_DONE;
							REQ_RUN:   state_q <= (passes == '0) ? S_CRD : S_PRD;
							default:   state_q <= S_DONE;
						endcase
					end
				end
				S_RDWAIT: begin
					state_q <= S_DONE;
				end
				S_PRD: begin
					cnt_q <= cnt_q + 4'(vld_q & rdata);
					vld_q <= 1'b1;
					if (dc_q == 2'd2) begin
						dc_q <= 2'd0;
						if (dr_q == 2'd2) begin
							dr_q    <= 2'd0;
							state_q <= S_PWR;
						end else begin
							dr_q <= dr_q + 2'd1;
						end
					end else begin
						dc_q <= dc_q + 2'd1;
					end
				end
				S_PWR: begin
					cnt_q <= '0;
					vld_q <= 1'b0;
					if (last_cell) begin
						r_q    <= '0;
						c_q    <= '0;
						cur_q  <= !cur_q;
						pass_q <= pass_q + 4'd1;
						state_q <= last_pass ? S_CRD : S_PRD;
					end else begin
						state_q <= S_PRD;
						if (c_q == CW'(COLS - 1)) begin
							c_q <= '0;
							r_q <= r_q + RW'(1);
						end else begin
							c_q <= c_q + CW'(1);
						end
					end
				end
				S_CRD: begin
					total_q <= total_q + TOTAL_W'(vld_q & rdata);
					vld_q   <= 1'b1;
					if (last_cell) begin
						state_q <= S_CLAST;
					end else if (c_q == CW'(COLS - 1)) begin
						c_q <= '0;
						r_q <= r_q + RW'(1);
					end else begin
						c_q <= c_q + CW'(1);
					end
				end
				S_CLAST: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/cave_automaton_smoother.sv]
// Top level of the cave smoothing automaton with configuration and result register.
//
// Channel   Direction  Carries
// req       in         req_type, row, col, wall_in
// rsp       out        wall_out, wall_total, status
// cfg       in         cfg_we, cfg_index, cfg_wdata (write only)
//
// A write, an out-of-range or an unused request goes from idle straight to done, a read
// passes the read-wait state first; done then hands the result to the output register.
// Each pass reads a cell's nine neighbors, then writes it; a last sweep counts the walls.
// The pass time is set by the single read port of the grid memory, one neighbor per cycle.
// Reset clears control and restores the registers; grid contents are undefined until written.
// A new item is accepted while the previous result waits in the output register.
module cave_automaton_smoother import cas_pkg::*; #(
	parameter int ROWS = 32,
	parameter int COLS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	cas_req_if.sink          req,
	cas_rsp_if.source        rsp,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int CELLS = ROWS * COLS;
	localparam int AW    = $clog2(CELLS);

	logic [CFG_W-1:0] threshold_q;
	logic [CFG_W-1:0] passes_q;
	logic             out_valid_q;
	rsp_t             out_q;

	addr_req_t        areq;
	mem_ctl_t         mctl;
	logic [AW-1:0]    addr;
	logic             rd_a;
	logic             rd_b;
	logic             rdata;
	logic             done;
	logic             out_free;
	rsp_t             res;

	assign out_free = !out_valid_q || rsp.ready;
	assign rdata    = mctl.sel_b ? rd_b : rd_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			passes_q    <= PASSES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_THRESHOLD: threshold_q <= cfg_wdata;
				CFG_PASSES:    passes_q    <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	cas_ctrl #(
		.ROWS(ROWS),
		.COLS(COLS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.req_type  (req.req_type),
		.row       (req.row),
		.col       (req.col),
		.wall_in   (req.wall_in),
		.threshold (threshold_q),
		.passes    (passes_q),
		.rdata     (rdata),
		.out_free  (out_free),
		.areq      (areq),
		.mctl      (mctl),
		.done      (done),
		.res       (res)
	);

	cas_addr #(
		.ROWS(ROWS),
		.COLS(COLS),
		.AW  (AW)
	) u_addr (
		.areq (areq),
		.addr (addr)
	);

	cas_ram #(
		.WIDTH(1),
		.DEPTH(CELLS)
	) u_grid_a (
		.clk   (clk),
		.we    (mctl.we_a),
		.addr  (addr),
		.wdata (mctl.wdata),
		.rdata (rd_a)
	);

	cas_ram #(
		.WIDTH(1),
		.DEPTH(CELLS)
	) u_grid_b (
		.clk   (clk),
		.we    (mctl.we_b),
		.addr  (addr),
		.wdata (mctl.wdata),
		.rdata (rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done && out_free) begin
			out_q <= res;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.wall_out   = out_q.wall_out;
	assign rsp.wall_total = out_q.wall_total;
	assign rsp.status     = out_q.status;

endmodule

[verif/smoother_checker.sv]
`timescale 1ns / 100ps
// Checker for the cave smoothing automaton: predicts every result and compares it.
module smoother_checker import cas_pkg::*; #(
	parameter int ROWS = 32,
	parameter int COLS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	cas_req_if               req,
	cas_rsp_if               rsp,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	output int               errors,
	output int               pending
);

	localparam int CELLS = ROWS * COLS;

	bit               grid [CELLS];
	logic [CFG_W-1:0] threshold;
	logic [CFG_W-1:0] passes;
	rsp_t             replies_due [$];

	function automatic int neighbor_walls(int r, int c);
		int n;
		int rr;
		int cc;
		n = 0;
		for (int dr = -1; dr <= 1; dr++) begin
			rr = (r + ROWS + dr) % ROWS;
			for (int dc = -1; dc <= 1; dc++) begin
				cc = (c + COLS + dc) % COLS;
				n += grid[rr * COLS + cc];
			end
		end
		return n;
	endfunction

	function automatic void smooth_grid();
		bit fresh [CELLS];
		for (int r = 0; r < ROWS; r++)
			for (int c = 0; c < COLS; c++)
				fresh[r * COLS + c] = (neighbor_walls(r, c) >= int'(threshold));
		grid = fresh;
	endfunction

	function automatic rsp_t predict_reply(logic [1:0] kind, logic [7:0] row,
		logic [7:0] col, logic wall);
		rsp_t reply;
		int   total;
		reply = '0;
		total = 0;
		if (kind == REQ_WRITE || kind == REQ_READ) begin
			if (row >= ROWS || col >= COLS)
				reply.status = 1'b1;
			else if (kind == REQ_WRITE)
				grid[int'(row) * COLS + int'(col)] = wall;
			else
				reply.wall_out = grid[int'(row) * COLS + int'(col)];
		end else if (kind == REQ_RUN) begin
			repeat (passes) smooth_grid();
			foreach (grid[i]) total += grid[i];
			reply.wall_total = TOTAL_W'(total);
		end
		return reply;
	endfunction

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		rsp_t due;
		if (!arst_n) begin
			threshold = THRESHOLD_RST;
			passes = PASSES_RST;
			replies_due.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (replies_due.size() == 0) begin
					errors++;
					$display("%0t: result with nothing expected: wall_out %0d wall_total %0d status %0d",
						$time, rsp.wall_out, rsp.wall_total, rsp.status);
				end else begin
					due = replies_due.pop_front();
					if (rsp.wall_out !== due.wall_out) begin
						errors++;
						$display("%0t: wall_out expected %0d, got %0d", $time, due.wall_out,
							rsp.wall_out);
					end
					if (rsp.wall_total !== due.wall_total) begin
						errors++;
						$display("%0t: wall_total expected %0d, got %0d", $time, due.wall_total,
							rsp.wall_total);
					end
					if (rsp.status !== due.status) begin
						errors++;
						$display("%0t: status expected %0d, got %0d", $time, due.status,
							rsp.status);
					end
				end
			end
			if (req.valid && req.ready)
				replies_due.push_back(predict_reply(req.req_type, req.row, req.col, req.wall_in));
			if (cfg_we) begin
				if (cfg_index == CFG_THRESHOLD)
					threshold = cfg_wdata;
				else
					passes = cfg_wdata;
			end
		end
		pending = replies_due.size();
	end

endmodule

[verif/tb_cave_automaton_smoother.sv]
`timescale 1ns / 100ps
// Testbench top for the cave smoothing automaton: stimulus, handshake pacing and verdict.
module tb_cave_automaton_smoother;
	import cas_pkg::*;

	localparam int ROWS = 32;
	localparam int COLS = 64;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int IDLE_PCT = 24;
	localparam int STALL_LIMIT = 4 * (16 * 10 * ROWS * COLS + ROWS * COLS);
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 40;
	localparam logic [CFG_W-1:0] THRESHOLD_PLAN [PHASES] = '{5, 5, 4, 6, 5, 9, 3, 0, 10, 12};
	localparam logic [CFG_W-1:0] PASSES_PLAN [PHASES] = '{2, 0, 1, 2, 15, 1, 1, 1, 1, 1};

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_wdata;
	int               errors;
	int               pending;
	bit               steady;
	int               stall_cycles;
	int               n_items;
	int               n_writes;
	int               n_reads;
	int               n_runs;
	int               n_outside;
	int               n_unused;

	cas_req_if req_ch ();
	cas_rsp_if rsp_ch ();

	cave_automaton_smoother #(.ROWS(ROWS), .COLS(COLS)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	smoother_checker #(.ROWS(ROWS), .COLS(COLS)) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(negedge clk) begin
		rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Watchdog expired after %0d cycles without a handshake.", stall_cycles);
			$display("tb_cave_automaton_smoother: errors");
			$finish;
		end
	end

	task automatic send_item(input logic [1:0] kind, input logic [7:0] row,
		input logic [7:0] col, input logic wall);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.row <= row;
		req_ch.col <= col;
		req_ch.wall_in <= wall;
		do @(posedge clk); while (!req_ch.ready);
		n_items++;
		case (kind)
			REQ_WRITE: n_writes++;
			REQ_READ:  n_reads++;
			REQ_RUN:   n_runs++;
			default:   n_unused++;
		endcase
		if ((kind == REQ_WRITE || kind == REQ_READ) && (row >= ROWS || col >= COLS))
			n_outside++;
	endtask

	task automatic send_random();
		int         pick;
		logic [7:0] r;
		logic [7:0] c;
		pick = $urandom_range(99);
		r = 8'($urandom_range(ROWS - 1));
		c = 8'($urandom_range(COLS - 1));
		if (pick < 45) begin
			send_item(REQ_WRITE, r, c, 1'($urandom_range(1)));
		end else if (pick < 80) begin
			send_item(REQ_READ, r, c, 1'($urandom_range(1)));
		end else if (pick < 93) begin
			if ($urandom_range(1))
				r = 8'($urandom_range(255, ROWS));
			else
				c = 8'($urandom_range(255, COLS));
			send_item(pick[0] ? REQ_READ : REQ_WRITE, r, c, 1'($urandom_range(1)));
		end else begin
			send_item(REQ_UNUSED, 8'($urandom_range(255)), 8'($urandom_range(255)),
				1'($urandom_range(1)));
		end
	endtask

	// Leaves the request channel quiet until every expected result has been taken.
	task automatic drain();
		do begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end while (pending != 0);
	endtask

	task automatic set_config(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] np);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= CFG_THRESHOLD;
		cfg_wdata <= thr;
		@(negedge clk);
		cfg_index <= CFG_PASSES;
		cfg_wdata <= np;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_THRESHOLD;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_WRITE;
		req_ch.row = '0;
		req_ch.col = '0;
		req_ch.wall_in = 1'b0;
		rsp_ch.ready = 1'b0;
		steady = 1'b0;
		stall_cycles = 0;
		n_items = 0;
		n_writes = 0;
		n_reads = 0;
		n_runs = 0;
		n_outside = 0;
		n_unused = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Corners, an overwrite, the first rows and columns off the grid, and the unused type.
		send_item(REQ_WRITE, 8'd0, 8'd0, 1'b1);
		send_item(REQ_WRITE, 8'd0, 8'd63, 1'b1);
		send_item(REQ_WRITE, 8'd31, 8'd0, 1'b0);
		send_item(REQ_WRITE, 8'd31, 8'd63, 1'b1);
		send_item(REQ_WRITE, 8'd15, 8'd32, 1'b0);
		send_item(REQ_READ, 8'd0, 8'd0, 1'b0);
		send_item(REQ_READ, 8'd0, 8'd63, 1'b1);
		send_item(REQ_READ, 8'd31, 8'd0, 1'b1);
		send_item(REQ_READ, 8'd31, 8'd63, 1'b0);
		send_item(REQ_READ, 8'd15, 8'd32, 1'b1);
		send_item(REQ_WRITE, 8'd0, 8'd0, 1'b0);
		send_item(REQ_READ, 8'd0, 8'd0, 1'b0);
		send_item(REQ_WRITE, 8'd32, 8'd0, 1'b1);
		send_item(REQ_WRITE, 8'd0, 8'd64, 1'b1);
		send_item(REQ_WRITE, 8'd255, 8'd255, 1'b1);
		send_item(REQ_WRITE, 8'd255, 8'd0, 1'b0);
		send_item(REQ_READ, 8'd32, 8'd63, 1'b1);
		send_item(REQ_READ, 8'd31, 8'd64, 1'b0);
		send_item(REQ_READ, 8'd255, 8'd255, 1'b1);
		send_item(REQ_READ, 8'd0, 8'd255, 1'b0);
		send_item(REQ_UNUSED, 8'd255, 8'd255, 1'b1);
		send_item(REQ_UNUSED, 8'd0, 8'd0, 1'b0);

		// Every cell must hold a known value before the first run.
		steady = 1'b1;
		for (int r = 0; r < ROWS; r++) begin
			if (r == ROWS / 2)
				steady = 1'b0;
			for (int c = 0; c < COLS; c++)
				send_item(REQ_WRITE, 8'(r), 8'(c), 1'($urandom_range(99) < 45));
		end

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0)
				set_config(THRESHOLD_PLAN[p], PASSES_PLAN[p]);
			repeat (PHASE_ITEMS) send_random();
			send_item(REQ_RUN, 8'($urandom_range(255)), 8'($urandom_range(255)),
				1'($urandom_range(1)));
		end

		drain();
		repeat (20) @(posedge clk);
		$display("Sent %0d items: %0d cell writes, %0d reads, %0d runs, %0d off the grid, %0d unused.",
			n_items, n_writes, n_reads, n_runs, n_outside, n_unused);
		$display("Runs covered %0d settings, threshold 0 to 12 and 0 to 15 passes per run.",
			PHASES);
		if (errors == 0)
			$display("tb_cave_automaton_smoother: clean");
		else
			$display("tb_cave_automaton_smoother: errors");
		$finish;
	end

endmodule
